@@ rtl/adq_pkg.sv @@
`default_nettype none

package adq_pkg;

   // Storage geometry and field widths.
   localparam int DEPTH    = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int DATA_W   = 32;
   localparam int LIMIT_W  = 6;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

   // Command codes carried on the request channel.
   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_REAR  = 3'd1,
      CMD_DEL_FRONT = 3'd2,
      CMD_DEL_REAR  = 3'd3,
      CMD_DISPLAY   = 3'd4
   } cmd_type;

   // Status codes carried on the response channel.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVF_FRONT = 2'd1,
      STAT_OVF_REAR  = 2'd2,
      STAT_UNDERFLOW = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_EMIT
   } state_type;

   // Request to the slot memory.
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

   // Operands for the shared index unit.
   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic             dec;
   } alu_req_type;

   // Results of the shared index unit.
   typedef struct packed {
      logic [IDX_W-1:0] sum;
      logic             equal;
   } alu_rsp_type;

endpackage

`default_nettype wire

@@ rtl/adq_req_if.sv @@
`default_nettype none

interface adq_req_if;
   logic                                valid;
   logic                                ready;
   logic        [adq_pkg::CMD_W-1:0]    cmd;
   logic signed [adq_pkg::DATA_W-1:0]   value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/adq_rsp_if.sv @@
`default_nettype none

interface adq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [adq_pkg::STATUS_W-1:0] status;
   logic signed [adq_pkg::DATA_W-1:0]   data;
   logic                                last;

   modport source (output valid, output status, output data, output last, input ready);
   modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/array_double_ended_queue.sv @@
`default_nettype none
// An insert, a delete or an error answer passes decode and emit into the output register.
// Display gives its first element likewise, then one per cycle unless the response stalls.
// A new command is taken only in idle, after the last result of the one before is loaded;
// an unknown command returns to idle from decode; a stalled response holds the input.
// The sequencer shares one index unit, and the slot-memory read is registered.
// Reset: synchronous, active high; the deque is empty and the limit returns to 32.

module array_double_ended_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [adq_pkg::LIMIT_W-1:0]   csr_write_data,
   adq_req_if.sink                            req_chan,
   adq_rsp_if.source                          rsp_chan
);

   adq_pkg::state_type               state_ff, state_in;
   logic [adq_pkg::CMD_W-1:0]        cmd_ff;
   logic [adq_pkg::DATA_W-1:0]       value_ff;
   logic [adq_pkg::IDX_W-1:0]        front_ff, front_in;
   logic [adq_pkg::IDX_W-1:0]        rear_ff, rear_in;
   logic                             empty_ff, empty_in;
   logic [adq_pkg::IDX_W-1:0]        cursor_ff, cursor_in;
   logic [adq_pkg::LIMIT_W-1:0]      limit_ff;
   adq_pkg::status_type              pend_status_ff, pend_status_in;
   logic                             pend_last_ff, pend_last_in;
   logic                             pend_mem_ff, pend_mem_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [adq_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [adq_pkg::DATA_W-1:0]       rsp_data_ff;
   logic                             rsp_last_ff;

   logic                             req_xfer;
   logic                             rsp_free;
   logic                             rsp_load;
   logic [adq_pkg::LIMIT_W-1:0]      lim;
   logic [adq_pkg::IDX_W-1:0]        lim_m1;
   logic [adq_pkg::IDX_W-1:0]        start;
   logic [adq_pkg::DATA_W-1:0]       rd_data;
   adq_pkg::mem_req_type             mem_req;
   adq_pkg::alu_req_type             alu_req;
   adq_pkg::alu_rsp_type             alu_rsp;

   adq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   adq_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_chan.ready = (state_ff == adq_pkg::S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Effective limit is clamped to the range one to the memory depth.
   always_comb begin
      if (limit_ff == '0) begin
         lim = adq_pkg::LIMIT_W'(1);
      end else if (limit_ff > adq_pkg::LIMIT_W'(adq_pkg::DEPTH)) begin
         lim = adq_pkg::LIMIT_W'(adq_pkg::DEPTH);
      end else begin
         lim = limit_ff;
      end
   end

   assign lim_m1 = adq_pkg::IDX_W'(lim - adq_pkg::LIMIT_W'(1));
   assign start  = adq_pkg::IDX_W'(lim >> 1);

   // Limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= adq_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Sequencer state and deque bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adq_pkg::S_IDLE;
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command capture, pending result and output payload.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_chan.cmd;
         value_ff <= req_chan.value;
      end
      cursor_ff      <= cursor_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      pend_mem_ff    <= pend_mem_in;
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= pend_mem_ff ? rd_data : '0;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   // Next state, index updates and memory requests.
   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      rear_in        = rear_ff;
      empty_in       = empty_ff;
      cursor_in      = cursor_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      pend_mem_in    = pend_mem_ff;
      rsp_load       = 1'b0;
      mem_req        = '0;
      mem_req.wr_data = value_ff;
      alu_req.a      = front_ff;
      alu_req.b      = rear_ff;
      alu_req.dec    = 1'b0;

      case (state_ff)
         adq_pkg::S_IDLE: begin
            if (req_xfer) begin
               state_in = adq_pkg::S_DECODE;
            end
         end

         adq_pkg::S_DECODE: begin
            state_in       = adq_pkg::S_EMIT;
            pend_status_in = adq_pkg::STAT_OK;
            pend_last_in   = 1'b1;
            pend_mem_in    = 1'b0;
            case (cmd_ff)
               adq_pkg::CMD_INS_FRONT: begin
                  alu_req.a   = front_ff;
                  alu_req.dec = 1'b1;
                  if (empty_ff) begin
                     front_in        = start;
                     rear_in         = start;
                     empty_in        = 1'b0;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = start;
                  end else if (front_ff == '0) begin
                     pend_status_in = adq_pkg::STAT_OVF_FRONT;
                  end else begin
                     front_in        = alu_rsp.sum;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = alu_rsp.sum;
                  end
               end
               adq_pkg::CMD_INS_REAR: begin
                  alu_req.a = rear_ff;
                  if (empty_ff) begin
                     front_in        = start;
                     rear_in         = start;
                     empty_in        = 1'b0;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = start;
                  end else if (rear_ff >= lim_m1) begin
                     pend_status_in = adq_pkg::STAT_OVF_REAR;
                  end else begin
                     rear_in         = alu_rsp.sum;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = alu_rsp.sum;
                  end
               end
               adq_pkg::CMD_DEL_FRONT, adq_pkg::CMD_DEL_REAR: begin
                  alu_req.a   = (cmd_ff == adq_pkg::CMD_DEL_FRONT) ? front_ff : rear_ff;
                  alu_req.dec = (cmd_ff == adq_pkg::CMD_DEL_REAR);
                  if (empty_ff) begin
                     pend_status_in = adq_pkg::STAT_UNDERFLOW;
                  end else begin
                     pend_mem_in     = 1'b1;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = alu_req.a;
                     if (front_ff == rear_ff) begin
                        empty_in = 1'b1;
                        front_in = '0;
                        rear_in  = '0;
                     end else if (cmd_ff == adq_pkg::CMD_DEL_FRONT) begin
                        front_in = alu_rsp.sum;
                     end else begin
                        rear_in = alu_rsp.sum;
                     end
                  end
               end
               adq_pkg::CMD_DISPLAY: begin
                  if (empty_ff) begin
                     pend_status_in = adq_pkg::STAT_UNDERFLOW;
                  end else begin
                     pend_mem_in     = 1'b1;
                     pend_last_in    = (front_ff == rear_ff);
                     cursor_in       = front_ff;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = front_ff;
                  end
               end
               default: begin
                  // Unknown commands give no result.
                  state_in = adq_pkg::S_IDLE;
               end
            endcase
         end

         adq_pkg::S_EMIT: begin
            alu_req.a = cursor_ff;
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (pend_last_ff) begin
                  state_in = adq_pkg::S_IDLE;
               end else begin
                  // Walk on to the next displayed element.
                  cursor_in       = alu_rsp.sum;
                  pend_last_in    = alu_rsp.equal;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = alu_rsp.sum;
               end
            end
         end

         default: begin
            state_in = adq_pkg::S_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // One command at a time: ready drops after each transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("request taken while a command is in progress");

   // A non-empty deque never has its front past its rear.
   assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (front_ff <= rear_ff))
      else $error("front index beyond rear index");

   // An empty deque keeps both indices at zero.
   assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0 && rear_ff == '0))
      else $error("empty deque with stale indices");

   // Error answers are always the only result of their command.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != adq_pkg::STAT_OK) |-> rsp_chan.last)
      else $error("error response not flagged as last");

endmodule

`default_nettype wire

@@ rtl/adq_mem.sv @@
`default_nettype none

module adq_mem (
   input  wire logic                         clock,
   input  wire adq_pkg::mem_req_type         mem_req,
   output logic      [adq_pkg::DATA_W-1:0]   rd_data
);

   logic [adq_pkg::DATA_W-1:0] slots [adq_pkg::DEPTH];
   logic [adq_pkg::DATA_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slots[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= slots[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/adq_alu.sv @@
`default_nettype none

module adq_alu (
   input  wire adq_pkg::alu_req_type alu_req,
   output adq_pkg::alu_rsp_type      alu_rsp
);

   logic [adq_pkg::IDX_W-1:0] step;
   logic [adq_pkg::IDX_W-1:0] sum;

   // Step by one in either direction; a decrement adds all ones.
   assign step = alu_req.dec ? '1 : adq_pkg::IDX_W'(1);
   assign sum  = alu_req.a + step;

   // The stepped index is compared with the second operand.
   assign alu_rsp.sum   = sum;
   assign alu_rsp.equal = (sum == alu_req.b);

endmodule

`default_nettype wire
